### hw/rtl/pfs_pkg.sv
// Shared types, constants and lookup functions for the palette fade sequencer.
package pfs_pkg;

  localparam int PEN_W      = 5;
  localparam int LEVEL_W    = 4;
  localparam int FRAME_W    = 8;
  localparam int ENTRY_W    = 6;
  localparam int HW_W       = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [LEVEL_W-1:0] IN_LEVELS  = LEVEL_W'(9);
  localparam logic [LEVEL_W-1:0] OUT_LEVELS = LEVEL_W'(6);
  localparam logic [HW_W-1:0]    BLACK_HW   = 5'h14;

  localparam logic [PEN_W-1:0]   RANGE_FIRST_RST = 5'd0;
  localparam logic [PEN_W-1:0]   RANGE_LAST_RST  = 5'd16;
  localparam logic [FRAME_W-1:0] FRAME_DELAY_RST = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_FIRST = 2'd0,
    CFG_RANGE_LAST  = 2'd1,
    CFG_FRAME_DELAY = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_START   = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_BLACKEN = 2'd3
  } action_t;

  typedef struct packed {
    action_t          action;
    logic [PEN_W-1:0] entry_index;
    logic [1:0]       red_level;
    logic [1:0]       green_level;
    logic [1:0]       blue_level;
    logic             direction;
  } item_t;

  typedef struct packed {
    logic             write_valid;
    logic [PEN_W-1:0] pen_index;
    logic [HW_W-1:0]  hw_colour;
    logic             last;
    logic             finished;
  } result_t;

  typedef struct packed {
    logic [1:0] r;
    logic [1:0] g;
    logic [1:0] b;
  } lim_t;

  // Read request from the sequencer to the output path.
  typedef struct packed {
    logic             valid;
    logic [PEN_W-1:0] pen;
    logic             last;
    logic             black;
    logic             finished;
    lim_t             lim;
  } req_t;

  // Palette store write.
  typedef struct packed {
    logic               en;
    logic [PEN_W-1:0]   pen;
    logic [ENTRY_W-1:0] entry;
  } ram_wr_t;

  localparam logic [HW_W-1:0] HW_TABLE [27] = '{
    5'h14, 5'h04, 5'h15, 5'h16, 5'h06, 5'h17, 5'h12, 5'h02, 5'h13,
    5'h1C, 5'h18, 5'h1D, 5'h1E, 5'h00, 5'h1F, 5'h1A, 5'h19, 5'h1B,
    5'h0C, 5'h05, 5'h0D, 5'h0E, 5'h07, 5'h0F, 5'h0A, 5'h03, 5'h0B
  };

  localparam lim_t IN_LIMITS [9] = '{
    '{2'd0, 2'd0, 2'd0}, '{2'd1, 2'd0, 2'd0}, '{2'd2, 2'd0, 2'd0},
    '{2'd3, 2'd0, 2'd0}, '{2'd3, 2'd1, 2'd0}, '{2'd3, 2'd2, 2'd0},
    '{2'd3, 2'd3, 2'd0}, '{2'd3, 2'd3, 2'd1}, '{2'd3, 2'd3, 2'd2}
  };

  localparam lim_t OUT_LIMITS [6] = '{
    '{2'd1, 2'd2, 2'd2}, '{2'd0, 2'd2, 2'd2}, '{2'd0, 2'd1, 2'd2},
    '{2'd0, 2'd0, 2'd2}, '{2'd0, 2'd0, 2'd1}, '{2'd0, 2'd0, 2'd0}
  };

  function automatic logic [1:0] sat2(input logic [1:0] v);
    return (v == 2'd3) ? 2'd2 : v;
  endfunction

  function automatic logic [1:0] min2(input logic [1:0] a, input logic [1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [HW_W-1:0] hw_lookup(input logic [4:0] idx);
    return (idx < 5'd27) ? HW_TABLE[idx] : BLACK_HW;
  endfunction

  function automatic lim_t fade_limit(input logic dir, input logic [LEVEL_W-1:0] level);
    lim_t l;
    l = '0;
    if (dir) begin
      if (level < OUT_LEVELS) l = OUT_LIMITS[level[2:0]];
    end else begin
      if (level < IN_LEVELS) l = IN_LIMITS[level];
    end
    return l;
  endfunction

endpackage

### hw/rtl/pfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pfs_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 17,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### hw/rtl/pfs_ctrl.sv
// Fade state, configuration registers and per-pen read sequencer.
module pfs_ctrl #(
  parameter int PEN_COUNT = 17
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  pfs_pkg::item_t                    item,
  output pfs_pkg::req_t                     req,
  input  logic                              take,
  output pfs_pkg::ram_wr_t                  wr
);

  typedef enum logic [1:0] {IDLE, RUN, FIN} state_t;

  localparam logic [pfs_pkg::PEN_W-1:0] MAX_PEN = pfs_pkg::PEN_W'(PEN_COUNT - 1);

  state_t                          state;
  logic [pfs_pkg::PEN_W-1:0]       range_first;
  logic [pfs_pkg::PEN_W-1:0]       range_last;
  logic [pfs_pkg::FRAME_W-1:0]     frame_delay;
  logic                            fade_active;
  logic                            fade_dir;
  logic [pfs_pkg::LEVEL_W-1:0]     level;
  logic [pfs_pkg::FRAME_W-1:0]     frame_count;
  logic [pfs_pkg::PEN_W-1:0]       pen;
  logic [pfs_pkg::PEN_W-1:0]       pen_last;
  logic                            black;

  logic                            accept;
  logic [pfs_pkg::PEN_W-1:0]       clip_last;
  logic                            range_empty;
  logic [pfs_pkg::FRAME_W-1:0]     wait_eff;
  logic [pfs_pkg::LEVEL_W-1:0]     level_count;
  logic [pfs_pkg::LEVEL_W-1:0]     level_next;
  logic                            issue;

  assign item_ready  = (state == IDLE);
  assign accept      = item_valid && item_ready;
  assign clip_last   = (range_last > MAX_PEN) ? MAX_PEN : range_last;
  assign range_empty = (range_first > clip_last);
  assign wait_eff    = (frame_delay == '0) ? pfs_pkg::FRAME_W'(1) : frame_delay;
  assign level_count = fade_dir ? pfs_pkg::OUT_LEVELS : pfs_pkg::IN_LEVELS;
  assign level_next  = level + pfs_pkg::LEVEL_W'(1);
  assign issue       = req.valid && take;

  always_comb begin
    req.valid    = (state == RUN) || (state == FIN);
    req.pen      = (state == FIN) ? '0 : pen;
    req.last     = (state == FIN) || (pen == pen_last);
    req.black    = black;
    req.finished = (state == FIN);
    req.lim      = pfs_pkg::fade_limit(fade_dir, level);
  end

  always_comb begin
    wr.en    = accept && (item.action == pfs_pkg::ACT_LOAD)
               && ({1'b0, item.entry_index} < (pfs_pkg::PEN_W + 1)'(PEN_COUNT));
    wr.pen   = item.entry_index;
    wr.entry = {pfs_pkg::sat2(item.red_level), pfs_pkg::sat2(item.green_level),
                pfs_pkg::sat2(item.blue_level)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      range_first <= pfs_pkg::RANGE_FIRST_RST;
      range_last  <= pfs_pkg::RANGE_LAST_RST;
      frame_delay <= pfs_pkg::FRAME_DELAY_RST;
      fade_active <= 1'b0;
      fade_dir    <= 1'b0;
      level       <= '0;
      frame_count <= '0;
      pen         <= '0;
      pen_last    <= '0;
      black       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pfs_pkg::CFG_RANGE_FIRST: range_first <= cfg_data[pfs_pkg::PEN_W-1:0];
          pfs_pkg::CFG_RANGE_LAST:  range_last  <= cfg_data[pfs_pkg::PEN_W-1:0];
          pfs_pkg::CFG_FRAME_DELAY: frame_delay <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            pen      <= range_first;
            pen_last <= clip_last;
            unique case (item.action)
              pfs_pkg::ACT_LOAD: ;
              pfs_pkg::ACT_START: begin
                fade_active <= 1'b1;
                fade_dir    <= item.direction;
                level       <= '0;
                frame_count <= wait_eff;
                black       <= 1'b0;
                if (!range_empty) state <= RUN;
              end
              pfs_pkg::ACT_TICK: begin
                if (fade_active) begin
                  if (frame_count > pfs_pkg::FRAME_W'(1)) begin
                    frame_count <= frame_count - pfs_pkg::FRAME_W'(1);
                  end else if (level_next >= level_count) begin
                    frame_count <= '0;
                    fade_active <= 1'b0;
                    level       <= '0;
                    state       <= FIN;
                  end else begin
                    frame_count <= wait_eff;
                    level       <= level_next;
                    black       <= 1'b0;
                    if (!range_empty) state <= RUN;
                  end
                end
              end
              pfs_pkg::ACT_BLACKEN: begin
                black <= 1'b1;
                if (!range_empty) state <= RUN;
              end
              default: ;
            endcase
          end
        end
        RUN: begin
          if (issue) begin
            pen <= pen + pfs_pkg::PEN_W'(1);
            if (pen == pen_last) state <= IDLE;
          end
        end
        FIN: begin
          if (issue) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level < level_count)
    else $error("fade level out of range");

  a_idle_level: assert property (@(posedge clk) disable iff (rst)
    !fade_active |-> (level == '0))
    else $error("level not cleared after fade");

  a_pen_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |-> (pen >= range_first) && (pen <= pen_last) && (pen_last <= MAX_PEN))
    else $error("pen outside range");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (issue && req.last) |=> (state == IDLE))
    else $error("sequencer kept running after last beat");

endmodule

### hw/rtl/pfs_out.sv
// Read-data stage, colour clamp and lookup, and the result register.
module pfs_out (
  input  logic                              clk,
  input  logic                              rst,
  input  pfs_pkg::req_t                     req,
  output logic                              take,
  input  logic [pfs_pkg::ENTRY_W-1:0]       rdata,
  output logic                              result_valid,
  input  logic                              result_ready,
  output pfs_pkg::result_t                  result
);

  logic             s1_valid;
  pfs_pkg::req_t    s1;
  logic             s1_adv;
  logic [1:0]       r;
  logic [1:0]       g;
  logic [1:0]       b;
  logic [4:0]       idx;
  pfs_pkg::result_t res_next;

  assign s1_adv = s1_valid && (!result_valid || result_ready);
  assign take   = !s1_valid || s1_adv;

  always_comb begin
    r   = pfs_pkg::min2(rdata[5:4], s1.lim.r);
    g   = pfs_pkg::min2(rdata[3:2], s1.lim.g);
    b   = pfs_pkg::min2(rdata[1:0], s1.lim.b);
    idx = ({3'b0, r} * 5'd9) + ({3'b0, g} * 5'd3) + {3'b0, b};
    if (s1.finished) begin
      res_next = '{write_valid: 1'b0, pen_index: '0, hw_colour: '0,
                   last: 1'b1, finished: 1'b1};
    end else begin
      res_next.write_valid = 1'b1;
      res_next.pen_index   = s1.pen;
      res_next.hw_colour   = s1.black ? pfs_pkg::BLACK_HW : pfs_pkg::hw_lookup(idx);
      res_next.last        = s1.last;
      res_next.finished    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (take) s1_valid <= req.valid;
      if (s1_adv) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && req.valid) s1 <= req;
    if (s1_adv) result <= res_next;
  end

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && result_valid && !result_ready) |=> s1_valid && $stable(s1))
    else $error("read stage lost a beat under stall");

endmodule

### hw/rtl/palette_fade_sequencer.sv
// Palette fade sequencer top level: palette store, sequencer and output path.
//
//  channel   dir  handshake                   payload
//  item      in   item_valid / item_ready     pfs_pkg::item_t
//  result    out  result_valid / result_ready pfs_pkg::result_t
//  cfg       in   cfg_we (no wait)            cfg_index, cfg_data
//
// A start, blacken or level-advancing tick issues one pen per cycle, unless
// result_ready stalls it, from the single palette read port; a fade-ending
// tick issues one finished beat. Each read is registered in the read stage,
// then in the result register. Reset clears fade state and resets the
// configuration to its defaults; palette entries are undefined until loaded,
// with no clearing pass. result_ready low holds the result and the read stage
// and pauses the sequencer; item_ready is low while it issues.
module palette_fade_sequencer #(
  parameter int PEN_COUNT = 17
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  pfs_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output pfs_pkg::result_t               result
);

  localparam int AW = (PEN_COUNT > 1) ? $clog2(PEN_COUNT) : 1;

  pfs_pkg::req_t                 req;
  pfs_pkg::ram_wr_t              wr;
  logic                          take;
  logic [pfs_pkg::ENTRY_W-1:0]   rdata;

  pfs_ctrl #(.PEN_COUNT(PEN_COUNT)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .req        (req),
    .take       (take),
    .wr         (wr)
  );

  pfs_ram #(.WIDTH(pfs_pkg::ENTRY_W), .DEPTH(PEN_COUNT)) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.pen[AW-1:0]),
    .wdata (wr.entry),
    .re    (req.valid && take),
    .raddr (req.pen[AW-1:0]),
    .rdata (rdata)
  );

  pfs_out u_out (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .take         (take),
    .rdata        (rdata),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
